### rtl/core/alf_pkg.sv
package alf_pkg;

	localparam int NODE_COUNT_DEF = 64;
	localparam int CMD_W          = 2;
	localparam int DATA_W         = 32;
	localparam int STATUS_W       = 2;
	localparam int S_TDATA_W      = 40;
	localparam int M_TDATA_W      = 40;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT   = 2'd0,
		CMD_TRAVERSE = 2'd1,
		CMD_DELETE   = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_INS,
		S_DEL,
		S_TRV,
		S_RESP
	} fsm_state_t;

	typedef struct packed {
		logic rd_en;
		logic link_we;
		logic value_we;
	} store_ctl_t;

endpackage

### rtl/core/alf_store.sv
module alf_store #(
	parameter int NODE_COUNT = alf_pkg::NODE_COUNT_DEF,
	localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1,
	localparam int LW = $clog2(NODE_COUNT + 1)
) (
	input  logic                       clk,
	input  alf_pkg::store_ctl_t        ctl,
	input  logic [AW-1:0]              rd_addr,
	input  logic [AW-1:0]              wr_addr,
	input  logic [LW-1:0]              link_wdata,
	input  logic [alf_pkg::DATA_W-1:0] value_wdata,
	output logic [LW-1:0]              link_rdata,
	output logic [alf_pkg::DATA_W-1:0] value_rdata
);
	import alf_pkg::*;

	logic [LW-1:0]     link_mem [NODE_COUNT];
	logic [DATA_W-1:0] value_mem [NODE_COUNT];

	always_ff @(posedge clk) begin
		if (ctl.link_we) begin
			link_mem[wr_addr] <= link_wdata;
		end
		if (ctl.rd_en) begin
			link_rdata <= link_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.value_we) begin
			value_mem[wr_addr] <= value_wdata;
		end
		if (ctl.rd_en) begin
			value_rdata <= value_mem[rd_addr];
		end
	end

endmodule

### rtl/core/alf_ctrl.sv
module alf_ctrl #(
	parameter int NODE_COUNT = alf_pkg::NODE_COUNT_DEF,
	localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1,
	localparam int LW = $clog2(NODE_COUNT + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [alf_pkg::CMD_W-1:0]    command,
	input  logic signed [alf_pkg::DATA_W-1:0] value,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [alf_pkg::STATUS_W-1:0] status,
	output logic signed [alf_pkg::DATA_W-1:0] data_out,
	output logic                         last,
	output alf_pkg::store_ctl_t          ctl,
	output logic [AW-1:0]                rd_addr,
	output logic [AW-1:0]                wr_addr,
	output logic [LW-1:0]                link_wdata,
	output logic [alf_pkg::DATA_W-1:0]   value_wdata,
	input  logic [LW-1:0]                link_rdata,
	input  logic [alf_pkg::DATA_W-1:0]   value_rdata
);
	import alf_pkg::*;

	localparam logic [LW-1:0] LINK_NULL = LW'(NODE_COUNT);
	localparam logic [AW-1:0] IDX_LAST  = AW'(NODE_COUNT - 1);

	fsm_state_t        state_q, state_d;
	logic [AW-1:0]     clr_q;
	logic [AW-1:0]     cnt_q;
	logic [LW-1:0]     head_q;
	logic [LW-1:0]     free_q;
	logic [DATA_W-1:0] val_q;
	status_t           status_q;
	logic              out_valid_q;
	status_t           out_status_q;
	logic [DATA_W-1:0] out_data_q;
	logic              out_last_q;

	cmd_t cmd;
	logic accept;
	logic out_free;
	logic head_ok;
	logic free_ok;
	logic next_ok;
	logic trv_last;
	logic out_load;

	assign cmd      = cmd_t'(command);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign head_ok  = head_q < LINK_NULL;
	assign free_ok  = free_q < LINK_NULL;
	assign next_ok  = link_rdata < LINK_NULL;
	assign trv_last = !next_ok || (cnt_q == IDX_LAST);

	assign m_tvalid = out_valid_q;
	assign status   = out_status_q;
	assign data_out = out_data_q;
	assign last     = out_last_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == IDX_LAST) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					unique case (cmd)
						CMD_INSERT:   state_d = free_ok ? S_INS : S_RESP;
						CMD_DELETE:   state_d = head_ok ? S_DEL : S_RESP;
						CMD_TRAVERSE: state_d = head_ok ? S_TRV : S_RESP;
						default:      state_d = S_IDLE;
					endcase
				end
			end
			S_INS, S_DEL: state_d = S_RESP;
			S_RESP: begin
				if (out_free) state_d = S_IDLE;
			end
			S_TRV: begin
				if (out_free && trv_last) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs and memory control
	always_comb begin
		s_tready    = 1'b0;
		ctl         = '0;
		rd_addr     = '0;
		wr_addr     = '0;
		link_wdata  = '0;
		value_wdata = val_q;
		out_load    = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				ctl.link_we = 1'b1;
				wr_addr     = clr_q;
				link_wdata  = LW'(clr_q) + LW'(1);
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (accept) begin
					unique case (cmd)
						CMD_INSERT: begin
							ctl.rd_en = free_ok;
							rd_addr   = free_q[AW-1:0];
						end
						CMD_DELETE, CMD_TRAVERSE: begin
							ctl.rd_en = head_ok;
							rd_addr   = head_q[AW-1:0];
						end
						default: ctl.rd_en = 1'b0;
					endcase
				end
			end
			S_INS: begin
				ctl.link_we  = 1'b1;
				ctl.value_we = 1'b1;
				wr_addr      = free_q[AW-1:0];
				link_wdata   = head_q;
			end
			S_DEL: begin
				ctl.link_we = 1'b1;
				wr_addr     = head_q[AW-1:0];
				link_wdata  = free_q;
			end
			S_TRV: begin
				out_load  = out_free;
				ctl.rd_en = out_free && !trv_last;
				rd_addr   = link_rdata[AW-1:0];
			end
			S_RESP: out_load = out_free;
			default: out_load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			head_q      <= LINK_NULL;
			free_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + AW'(1);
			if (accept) cnt_q <= '0;
			if (state_q == S_TRV && out_free && !trv_last) cnt_q <= cnt_q + AW'(1);
			if (state_q == S_INS) begin
				head_q <= free_q;
				free_q <= link_rdata;
			end
			if (state_q == S_DEL) begin
				head_q <= link_rdata;
				free_q <= head_q;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q    <= value;
			status_q <= (cmd == CMD_INSERT) ? ST_FULL : ST_EMPTY;
		end
		if (state_q == S_INS || state_q == S_DEL) status_q <= ST_OK;
		if (out_load) begin
			if (state_q == S_TRV) begin
				out_status_q <= ST_OK;
				out_data_q   <= value_rdata;
				out_last_q   <= trv_last;
			end else begin
				out_status_q <= status_q;
				out_data_q   <= '0;
				out_last_q   <= 1'b1;
			end
		end
	end

endmodule

### rtl/core/array_linked_list_free_list_core.sv
// Linked list of up to NODE_COUNT 32-bit values in an on-chip node store, with
// unused nodes chained on a free list. Commands: insert at head, delete head,
// traverse head to tail. A successful insert or delete reads the link memory
// and writes the node back in the next cycle. Its result then goes to the
// output register from the response state, which waits for the register to
// be free. A full or empty response skips the write and goes straight from
// idle to the response state. Traverse reads one node per cycle from the
// link and value memories, giving one result per cycle while m_tready stays
// high. The first result comes from the node read at acceptance, and the
// final one carries tlast. A command is accepted whenever the controller is
// idle, even while the previous result still waits in the output register.
// After reset the link memory is initialized in a pass over all NODE_COUNT
// nodes, during which s_tready is low. Command code 3 is accepted and dropped
// with no result.
module array_linked_list_free_list_core #(
	parameter int NODE_COUNT = alf_pkg::NODE_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [alf_pkg::S_TDATA_W-1:0] s_tdata,  // command[1:0], value[33:2], zero pad
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [alf_pkg::M_TDATA_W-1:0] m_tdata,  // status[1:0], data_out[33:2], zero pad
	output logic                          m_tlast
);
	import alf_pkg::*;

	localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int LW = $clog2(NODE_COUNT + 1);

	store_ctl_t               ctl;
	logic [AW-1:0]            rd_addr;
	logic [AW-1:0]            wr_addr;
	logic [LW-1:0]            link_wdata;
	logic [DATA_W-1:0]        value_wdata;
	logic [LW-1:0]            link_rdata;
	logic [DATA_W-1:0]        value_rdata;
	logic [STATUS_W-1:0]      status;
	logic signed [DATA_W-1:0] data_out;

	alf_ctrl #(
		.NODE_COUNT(NODE_COUNT)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.command    (s_tdata[CMD_W-1:0]),
		.value      (s_tdata[CMD_W+DATA_W-1:CMD_W]),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.status     (status),
		.data_out   (data_out),
		.last       (m_tlast),
		.ctl        (ctl),
		.rd_addr    (rd_addr),
		.wr_addr    (wr_addr),
		.link_wdata (link_wdata),
		.value_wdata(value_wdata),
		.link_rdata (link_rdata),
		.value_rdata(value_rdata)
	);

	alf_store #(
		.NODE_COUNT(NODE_COUNT)
	) u_store (
		.clk        (clk),
		.ctl        (ctl),
		.rd_addr    (rd_addr),
		.wr_addr    (wr_addr),
		.link_wdata (link_wdata),
		.value_wdata(value_wdata),
		.link_rdata (link_rdata),
		.value_rdata(value_rdata)
	);

	assign m_tdata = {(M_TDATA_W - STATUS_W - DATA_W)'(0), data_out, status};

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import alf_pkg::*;

	localparam int         NODES      = NODE_COUNT_DEF;
	localparam logic [1:0] CMD_NONE   = 2'd3;
	localparam int         MODE_FILL  = 0;
	localparam int         MODE_DRAIN = 1;
	localparam int         MODE_MIXED = 2;
	localparam int         RAND_ITEMS = 430;

	typedef struct {
		status_t     status;
		logic [31:0] data;
		logic        last;
	} resp_t;

	class list_tracker;
		logic [31:0] node_val [NODES];
		logic [6:0]  node_nxt [NODES];
		logic [6:0]  head;
		logic [6:0]  free_head;
		resp_t       pending_resp [$];
		int          mismatches;

		function new();
			for (int i = 0; i < NODES; i++) begin
				node_val[i] = '0;
				node_nxt[i] = 7'(i + 1);
			end
			head       = 7'(NODES);
			free_head  = '0;
			mismatches = 0;
		endfunction

		function void push_resp(status_t status, logic [31:0] data, logic last);
			resp_t r;
			r.status = status;
			r.data   = data;
			r.last   = last;
			pending_resp.push_back(r);
		endfunction

		function void accept_command(logic [1:0] code, logic [31:0] value);
			logic [6:0] node;
			logic [6:0] cur;
			logic [6:0] nxt;
			int         count;
			case (code)
				CMD_INSERT: begin
					if (free_head >= NODES) begin
						push_resp(ST_FULL, '0, 1'b1);
					end else begin
						node           = free_head;
						free_head      = node_nxt[node];
						node_val[node] = value;
						node_nxt[node] = head;
						head           = node;
						push_resp(ST_OK, '0, 1'b1);
					end
				end
				CMD_DELETE: begin
					if (head >= NODES) begin
						push_resp(ST_EMPTY, '0, 1'b1);
					end else begin
						node           = head;
						head           = node_nxt[node];
						node_nxt[node] = free_head;
						free_head      = node;
						push_resp(ST_OK, '0, 1'b1);
					end
				end
				CMD_TRAVERSE: begin
					if (head >= NODES) begin
						push_resp(ST_EMPTY, '0, 1'b1);
					end else begin
						cur   = head;
						count = 0;
						while (cur < NODES && count < NODES) begin
							nxt = node_nxt[cur];
							push_resp(ST_OK, node_val[cur], nxt >= NODES || count + 1 >= NODES);
							count++;
							cur = nxt;
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void check_response(logic [M_TDATA_W-1:0] tdata, logic tlast);
			resp_t       want;
			logic [1:0]  got_status;
			logic [31:0] got_data;
			got_status = tdata[1:0];
			got_data   = tdata[33:2];
			if (pending_resp.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: status %0d data %h last %b",
						got_status, got_data, tlast);
				mismatches++;
			end else begin
				want = pending_resp.pop_front();
				if (got_status !== want.status || got_data !== want.data
						|| tlast !== want.last) begin
					if (mismatches < 10)
						$display("result differs: expected status %0d data %h last %b, got status %0d data %h last %b",
							want.status, want.data, want.last, got_status, got_data, tlast);
					mismatches++;
				end
			end
		endfunction

		function int outstanding();
			return pending_resp.size();
		endfunction
	endclass

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tlast;

	list_tracker tracker;
	bit          src_idle = 1'b1;
	bit          snk_idle = 1'b1;
	bit          hold_req = 1'b0;

	array_linked_list_free_list_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 11))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_command(input logic [1:0] code, input logic [31:0] value);
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, value, code};
		do @(posedge clk); while (!s_tready);
		tracker.accept_command(code, value);
		if (src_idle && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// sink side: checks each transaction, then picks tready for the next cycle
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				tracker.check_response(m_tdata, m_tlast);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (snk_idle && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 15) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		int         sent;
		int         mode;
		int         run_len;
		int         roll;
		bit         held;
		logic [1:0] code;
		tracker = new();
		sent    = 0;
		held    = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// empty list, ignored code, extreme values
		send_command(CMD_TRAVERSE, 32'h1234_5678);
		send_command(CMD_DELETE, 32'hffff_ffff);
		send_command(CMD_NONE, 32'hdead_beef);
		send_command(CMD_INSERT, 32'h8000_0000);
		send_command(CMD_INSERT, 32'h7fff_ffff);
		send_command(CMD_INSERT, 32'h0000_0000);
		send_command(CMD_INSERT, 32'hffff_ffff);
		send_command(CMD_INSERT, 32'h5555_5555);
		send_command(CMD_INSERT, 32'haaaa_aaaa);
		send_command(CMD_TRAVERSE, '0);
		send_command(CMD_DELETE, '0);
		send_command(CMD_TRAVERSE, '0);
		send_command(CMD_NONE, 32'h0000_0000);
		repeat (5) send_command(CMD_DELETE, '0);
		send_command(CMD_DELETE, '0);
		send_command(CMD_TRAVERSE, '0);

		// random runs that lean toward filling, draining or neither
		while (sent < RAND_ITEMS) begin
			mode    = $urandom_range(MODE_FILL, MODE_MIXED);
			run_len = $urandom_range(20, 80);
			for (int k = 0; k < run_len && sent < RAND_ITEMS; k++) begin
				roll = $urandom_range(0, 99);
				case (mode)
					MODE_FILL:
						code = roll < 72 ? CMD_INSERT : roll < 82 ? CMD_TRAVERSE
							: roll < 97 ? CMD_DELETE : CMD_NONE;
					MODE_DRAIN:
						code = roll < 70 ? CMD_DELETE : roll < 82 ? CMD_TRAVERSE
							: roll < 97 ? CMD_INSERT : CMD_NONE;
					default:
						code = roll < 40 ? CMD_INSERT : roll < 58 ? CMD_TRAVERSE
							: roll < 96 ? CMD_DELETE : CMD_NONE;
				endcase
				if (!held && sent >= 200) begin
					held     = 1'b1;
					hold_req = 1'b1;
				end
				if (sent >= RAND_ITEMS - 60) begin
					src_idle = 1'b0;
					snk_idle = 1'b0;
				end
				send_command(code, pick_value());
				if (code != CMD_NONE)
					sent++;
			end
		end
		s_tvalid <= 1'b0;

		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("array_linked_list_free_list_core: match");
		else
			$display("array_linked_list_free_list_core: mismatch");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("array_linked_list_free_list_core: mismatch");
		$finish;
	end

endmodule

### array_linked_list_free_list_core.f
rtl/core/alf_pkg.sv
rtl/core/alf_store.sv
rtl/core/alf_ctrl.sv
rtl/core/array_linked_list_free_list_core.sv
dv/testbench.sv
